// ===== sv/ivs_pkg.sv =====
// shared definitions for the integer vector stack engine
// command codes, status codes, datapath micro-ops and the control/status structs
// no dependencies
`default_nettype none

package ivs_pkg;

  localparam int DEPTH_DEF = 1024;

  localparam int CMD_W = 3;
  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  localparam int LEN_W = 11;
  localparam int ST_W  = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_REVERSE = 3'd5;
  localparam logic [CMD_W-1:0] CMD_BUBBLE  = 3'd6;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE        = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD        = 5'd1;
  localparam logic [OP_W-1:0] OP_PUSH        = 5'd2;
  localparam logic [OP_W-1:0] OP_RD_TOP      = 5'd3;
  localparam logic [OP_W-1:0] OP_POP         = 5'd4;
  localparam logic [OP_W-1:0] OP_SET_WR      = 5'd5;
  localparam logic [OP_W-1:0] OP_FILL_INIT   = 5'd6;
  localparam logic [OP_W-1:0] OP_FILL        = 5'd7;
  localparam logic [OP_W-1:0] OP_CLEAR       = 5'd8;
  localparam logic [OP_W-1:0] OP_REV_INIT    = 5'd9;
  localparam logic [OP_W-1:0] OP_RD_PTR      = 5'd10;
  localparam logic [OP_W-1:0] OP_RD_HI_CAP   = 5'd11;
  localparam logic [OP_W-1:0] OP_WR_PTR_RD   = 5'd12;
  localparam logic [OP_W-1:0] OP_WR_HI_HOLD  = 5'd13;
  localparam logic [OP_W-1:0] OP_BUB_INIT    = 5'd14;
  localparam logic [OP_W-1:0] OP_CAP         = 5'd15;
  localparam logic [OP_W-1:0] OP_RD_PTRM1    = 5'd16;
  localparam logic [OP_W-1:0] OP_BUB_SHIFT   = 5'd17;
  localparam logic [OP_W-1:0] OP_WR_PTR_HOLD = 5'd18;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            fin;
    logic            take_rd;
    logic [ST_W-1:0] code;
  } ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic idx_oob;
    logic idx_lt_cnt;
    logic ge2;
    logic ptr_lt_hi;
    logic ptr_zero;
    logic fill_done;
    logic ordered;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/ivs_ctrl.sv =====
// command sequencer of the vector stack engine
// depends on ivs_pkg for command codes, micro-ops and the control/status structs
`default_nettype none

module ivs_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [ivs_pkg::CMD_W-1:0] cmd,
  input  wire ivs_pkg::sts_t           sts,
  output ivs_pkg::ctl_t                ctl,
  output logic                         busy
);
  import ivs_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DEC     = 4'd1;
  localparam logic [3:0] S_RDW     = 4'd2;
  localparam logic [3:0] S_FILL    = 4'd3;
  localparam logic [3:0] S_REV_RL  = 4'd4;
  localparam logic [3:0] S_REV_RH  = 4'd5;
  localparam logic [3:0] S_REV_WL  = 4'd6;
  localparam logic [3:0] S_REV_WH  = 4'd7;
  localparam logic [3:0] S_BUB_CAP = 4'd8;
  localparam logic [3:0] S_BUB_RD  = 4'd9;
  localparam logic [3:0] S_BUB_CMP = 4'd10;

  logic [3:0]       state, state_next;
  logic [CMD_W-1:0] cmd_q;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    if (state == S_IDLE && start) begin
      cmd_q <= cmd;
    end
  end

  always_comb begin
    state_next  = state;
    ctl.op      = OP_NONE;
    ctl.fin     = 1'b0;
    ctl.take_rd = 1'b0;
    ctl.code    = ST_OK;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.op     = OP_LOAD;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        state_next = S_IDLE;
        case (cmd_q)
          CMD_PUSH: begin
            ctl.fin = 1'b1;
            if (sts.full) begin
              ctl.code = ST_FULL;
            end else begin
              ctl.op = OP_PUSH;
            end
          end
          CMD_POP, CMD_PEEK: begin
            if (sts.empty) begin
              ctl.fin  = 1'b1;
              ctl.code = ST_EMPTY;
            end else begin
              ctl.op     = OP_RD_TOP;
              state_next = S_RDW;
            end
          end
          CMD_SET: begin
            if (sts.idx_oob) begin
              ctl.fin  = 1'b1;
              ctl.code = ST_FULL;
            end else if (sts.idx_lt_cnt) begin
              ctl.op  = OP_SET_WR;
              ctl.fin = 1'b1;
            end else begin
              ctl.op     = OP_FILL_INIT;
              state_next = S_FILL;
            end
          end
          CMD_CLEAR: begin
            ctl.op  = OP_CLEAR;
            ctl.fin = 1'b1;
          end
          CMD_REVERSE: begin
            if (sts.ge2) begin
              ctl.op     = OP_REV_INIT;
              state_next = S_REV_RL;
            end else begin
              ctl.fin = 1'b1;
            end
          end
          CMD_BUBBLE: begin
            if (sts.ge2) begin
              ctl.op     = OP_BUB_INIT;
              state_next = S_BUB_CAP;
            end else begin
              ctl.fin = 1'b1;
            end
          end
          default: begin
            ctl.fin = 1'b1;
          end
        endcase
      end
      S_RDW: begin
        ctl.op      = (cmd_q == CMD_POP) ? OP_POP : OP_NONE;
        ctl.fin     = 1'b1;
        ctl.take_rd = 1'b1;
        state_next  = S_IDLE;
      end
      S_FILL: begin
        if (sts.fill_done) begin
          ctl.op     = OP_SET_WR;
          ctl.fin    = 1'b1;
          state_next = S_IDLE;
        end else begin
          ctl.op = OP_FILL;
        end
      end
      S_REV_RL: begin
        if (sts.ptr_lt_hi) begin
          ctl.op     = OP_RD_PTR;
          state_next = S_REV_RH;
        end else begin
          ctl.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_REV_RH: begin
        ctl.op     = OP_RD_HI_CAP;
        state_next = S_REV_WL;
      end
      S_REV_WL: begin
        ctl.op     = OP_WR_PTR_RD;
        state_next = S_REV_WH;
      end
      S_REV_WH: begin
        ctl.op     = OP_WR_HI_HOLD;
        state_next = S_REV_RL;
      end
      S_BUB_CAP: begin
        ctl.op     = OP_CAP;
        state_next = S_BUB_RD;
      end
      S_BUB_RD: begin
        if (sts.ptr_zero) begin
          ctl.op     = OP_WR_PTR_HOLD;
          ctl.fin    = 1'b1;
          state_next = S_IDLE;
        end else begin
          ctl.op     = OP_RD_PTRM1;
          state_next = S_BUB_CMP;
        end
      end
      S_BUB_CMP: begin
        if (sts.ordered) begin
          ctl.op     = OP_WR_PTR_HOLD;
          ctl.fin    = 1'b1;
          state_next = S_IDLE;
        end else begin
          ctl.op     = OP_BUB_SHIFT;
          state_next = S_BUB_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/ivs_dpath.sv =====
// datapath of the vector stack engine: element memory, length, walk pointers, result regs
// depends on ivs_pkg for micro-op codes, status codes and the control/status structs
`default_nettype none

module ivs_dpath #(
  parameter int DEPTH = ivs_pkg::DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire ivs_pkg::ctl_t              ctl,
  input  wire logic [ivs_pkg::IDX_W-1:0]  index,
  input  wire logic signed [ivs_pkg::VAL_W-1:0] value,
  input  wire logic                       ascending,
  output ivs_pkg::sts_t                   sts,
  output logic                            done,
  output logic signed [ivs_pkg::VAL_W-1:0] read_value,
  output logic [ivs_pkg::LEN_W-1:0]       length,
  output logic [ivs_pkg::ST_W-1:0]        status
);
  import ivs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W + 1;

  logic [VAL_W-1:0] mem [DEPTH];

  logic [CW-1:0]    count, count_next;
  logic [AW-1:0]    ptr, ptr_next;
  logic [AW-1:0]    hi, hi_next;
  logic [VAL_W-1:0] hold;
  logic [VAL_W-1:0] rdata;
  logic [IDX_W-1:0] idx_q;
  logic [VAL_W-1:0] val_q;
  logic             asc_q;

  logic [AW-1:0]    raddr, waddr;
  logic [VAL_W-1:0] wdata;
  logic             we;
  logic             hold_ld;

  logic [XW-1:0]    idx_x, cnt_x, idx_p1;
  logic [CW-1:0]    cnt_m1;
  logic [AW-1:0]    top_a, idx_a;
  logic             cmp_ok;

  assign idx_x  = XW'(idx_q);
  assign cnt_x  = XW'(count);
  assign idx_p1 = idx_x + XW'(1);
  assign cnt_m1 = count - CW'(1);
  assign top_a  = cnt_m1[AW-1:0];
  assign idx_a  = idx_x[AW-1:0];

  // ordering test between the fetched neighbor and the moving element
  assign cmp_ok = asc_q ? ($signed(rdata) <= $signed(hold))
                        : ($signed(rdata) >= $signed(hold));

  always_comb begin
    sts.full       = (count >= CW'(DEPTH));
    sts.empty      = (count == '0);
    sts.idx_oob    = (idx_x >= XW'(DEPTH));
    sts.idx_lt_cnt = (idx_x < cnt_x);
    sts.ge2        = (count >= CW'(2));
    sts.ptr_lt_hi  = (ptr < hi);
    sts.ptr_zero   = (ptr == '0);
    sts.fill_done  = (ptr == idx_a);
    sts.ordered    = cmp_ok;
  end

  always_comb begin
    count_next = count;
    ptr_next   = ptr;
    hi_next    = hi;
    raddr      = ptr;
    waddr      = ptr;
    wdata      = hold;
    we         = 1'b0;
    hold_ld    = 1'b0;
    case (ctl.op)
      OP_PUSH: begin
        we         = 1'b1;
        waddr      = count[AW-1:0];
        wdata      = val_q;
        count_next = count + CW'(1);
      end
      OP_RD_TOP: begin
        raddr = top_a;
      end
      OP_POP: begin
        count_next = cnt_m1;
      end
      OP_SET_WR: begin
        we    = 1'b1;
        waddr = idx_a;
        wdata = val_q;
        if (!sts.idx_lt_cnt) begin
          count_next = idx_p1[CW-1:0];
        end
      end
      OP_FILL_INIT: begin
        ptr_next = count[AW-1:0];
      end
      OP_FILL: begin
        we       = 1'b1;
        wdata    = '0;
        ptr_next = ptr + AW'(1);
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      OP_REV_INIT: begin
        ptr_next = '0;
        hi_next  = top_a;
      end
      OP_RD_PTR: begin
        raddr = ptr;
      end
      OP_RD_HI_CAP: begin
        raddr   = hi;
        hold_ld = 1'b1;
      end
      OP_WR_PTR_RD: begin
        we    = 1'b1;
        wdata = rdata;
      end
      OP_WR_HI_HOLD: begin
        we       = 1'b1;
        waddr    = hi;
        ptr_next = ptr + AW'(1);
        hi_next  = hi - AW'(1);
      end
      OP_BUB_INIT: begin
        raddr    = top_a;
        ptr_next = top_a;
      end
      OP_CAP: begin
        hold_ld = 1'b1;
      end
      OP_RD_PTRM1: begin
        raddr = ptr - AW'(1);
      end
      OP_BUB_SHIFT: begin
        we       = 1'b1;
        wdata    = rdata;
        ptr_next = ptr - AW'(1);
      end
      OP_WR_PTR_HOLD: begin
        we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= ctl.fin;
    end
    ptr <= ptr_next;
    hi  <= hi_next;
    if (hold_ld) begin
      hold <= rdata;
    end
    if (ctl.op == OP_LOAD) begin
      idx_q <= index;
      val_q <= value;
      asc_q <= ascending;
    end
    if (ctl.fin) begin
      read_value <= ctl.take_rd ? $signed(rdata) : '0;
      length     <= LEN_W'(count_next);
      status     <= ctl.code;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("element count above capacity");

  a_empty_len: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> (length == '0))
    else $error("empty status with nonzero length");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (read_value == '0))
    else $error("nonzero read value on error result");

endmodule

`default_nettype wire

// ===== sv/int_vector_stack_engine.sv =====
// top level of the integer vector stack engine
// instantiates ivs_ctrl (sequencer) and ivs_dpath (memory and registers); uses ivs_pkg
//
//  channel   ports                                  handshake
//  command   cmd, index, value, ascending           start high while busy low
//  result    read_value, length, status             done high for one cycle, no stall
//
// steps (from the accepting edge to the done cycle, one result per command):
//   push, clear, errors, set within the length, reverse or bubble under two: settled in decode
//   pop and peek: decode, then a read-wait state for the registered memory read
//   set past the length: decode, then one zero fill per cycle up to the index, then the write
//   reverse of two or more: per swap, read low, read high, write low, write high
//   bubble last: capture the last word, then per move a neighbor read and a compare and shift, until front or order
// reset clears the length and the sequencer; the memory holds no reset value
// the result cannot be stalled; busy drops with the done cycle and a new beat may start then
`default_nettype none

module int_vector_stack_engine #(
  parameter int DEPTH = ivs_pkg::DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [ivs_pkg::CMD_W-1:0]         cmd,
  input  wire logic [ivs_pkg::IDX_W-1:0]         index,
  input  wire logic signed [ivs_pkg::VAL_W-1:0]  value,
  input  wire logic                              ascending,
  output logic                                   done,
  output logic signed [ivs_pkg::VAL_W-1:0]       read_value,
  output logic [ivs_pkg::LEN_W-1:0]              length,
  output logic [ivs_pkg::ST_W-1:0]               status
);
  import ivs_pkg::*;

  // micro-op stream from the sequencer and condition flags back from the datapath
  ctl_t ctl;
  sts_t sts;

  ivs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  // memory, length, walk pointers and the registered result beat
  ivs_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .index      (index),
    .value      (value),
    .ascending  (ascending),
    .sts        (sts),
    .done       (done),
    .read_value (read_value),
    .length     (length),
    .status     (status)
  );

endmodule

`default_nettype wire

// ===== test/ivs_stack_checker.sv =====
`timescale 1ns / 1ps
// result checker for the integer vector stack engine: predicts every command and compares
// the reply beats field by field; depends on ivs_pkg for widths and codes

module ivs_stack_checker #(
  parameter int DEPTH = ivs_pkg::DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic                              busy,
  input  wire logic [ivs_pkg::CMD_W-1:0]         cmd,
  input  wire logic [ivs_pkg::IDX_W-1:0]         index,
  input  wire logic signed [ivs_pkg::VAL_W-1:0]  value,
  input  wire logic                              ascending,
  input  wire logic                              done,
  input  wire logic signed [ivs_pkg::VAL_W-1:0]  read_value,
  input  wire logic [ivs_pkg::LEN_W-1:0]         length,
  input  wire logic [ivs_pkg::ST_W-1:0]          status,
  output int unsigned                            fail_count,
  output int unsigned                            awaited
);
  import ivs_pkg::*;

  typedef struct packed {
    logic signed [VAL_W-1:0] word;
    logic [LEN_W-1:0]        len;
    logic [ST_W-1:0]         code;
  } reply_t;

  logic signed [VAL_W-1:0] words [DEPTH];
  int unsigned             fill = 0;
  reply_t                  replies_due [$];
  reply_t                  want;
  int unsigned             miss_total = 0;

  assign fail_count = miss_total;

  task automatic report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] exp_v);
    miss_total++;
    $display("[%0t] mismatch on %s: got %0h, wanted %0h", $time, what, got, exp_v);
  endtask

  // applies one command to the shadow array and returns the reply it must produce
  function automatic reply_t apply_stack_cmd(logic [CMD_W-1:0] c, logic [IDX_W-1:0] idx,
                                             logic signed [VAL_W-1:0] val, logic asc);
    reply_t                  r;
    int unsigned             lo, hi, j;
    logic signed [VAL_W-1:0] t;
    r = '0;
    r.code = ST_OK;
    case (c)
      CMD_PUSH: begin
        if (fill >= DEPTH) r.code = ST_FULL;
        else begin
          words[fill] = val;
          fill++;
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (fill == 0) r.code = ST_EMPTY;
        else begin
          r.word = words[fill-1];
          if (c == CMD_POP) fill--;
        end
      end
      CMD_SET: begin
        if (idx >= DEPTH) r.code = ST_FULL;
        else begin
          // a gap past the length reads back as zeros
          if (idx >= fill) begin
            for (j = fill; j < idx; j++) words[j] = '0;
            fill = idx + 1;
          end
          words[idx] = val;
        end
      end
      CMD_CLEAR: fill = 0;
      CMD_REVERSE: begin
        if (fill >= 2) begin
          lo = 0;
          hi = fill - 1;
          while (hi > lo) begin
            t = words[hi];
            words[hi] = words[lo];
            words[lo] = t;
            hi--;
            lo++;
          end
        end
      end
      CMD_BUBBLE: begin
        if (fill >= 2) begin
          j = fill - 1;
          while (j > 0 && !(asc ? (words[j-1] <= words[j]) : (words[j-1] >= words[j]))) begin
            t = words[j-1];
            words[j-1] = words[j];
            words[j] = t;
            j--;
          end
        end
      end
      default: ;
    endcase
    r.len = LEN_W'(fill);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fill = 0;
      replies_due.delete();
    end else begin
      if (done) begin
        if (replies_due.size() == 0) report_mismatch("reply with nothing pending", '0, '0);
        else begin
          want = replies_due.pop_front();
          if (read_value !== want.word) report_mismatch("read_value", read_value, want.word);
          if (length !== want.len) report_mismatch("length", VAL_W'(length), VAL_W'(want.len));
          if (status !== want.code) report_mismatch("status", VAL_W'(status), VAL_W'(want.code));
        end
      end
      if (start && !busy)
        replies_due.push_back(apply_stack_cmd(cmd, index, value, ascending));
    end
    awaited <= replies_due.size();
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// top of the integer vector stack engine testbench: clock, reset, command stimulus, verdict
// depends on ivs_pkg, int_vector_stack_engine and ivs_stack_checker

module tb_top;
  import ivs_pkg::*;

  // the one command code the block leaves unused
  localparam logic [CMD_W-1:0] CMD_UNUSED   = 3'd7;
  localparam int unsigned      RANDOM_BEATS = 550;
  // no idle gaps in the closing stretch of the run
  localparam int unsigned      CLOSING_RUN  = 80;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic [CMD_W-1:0]        cmd = CMD_PUSH;
  logic [IDX_W-1:0]        index = '0;
  logic signed [VAL_W-1:0] value = '0;
  logic                    ascending = 1'b0;
  logic                    busy;
  logic                    done;
  logic signed [VAL_W-1:0] read_value;
  logic [LEN_W-1:0]        length;
  logic [ST_W-1:0]         status;
  int unsigned             fail_count;
  int unsigned             awaited;

  // set at the edge that takes a command beat, seen at the following falling edge
  logic                    beat_taken = 1'b0;
  int unsigned             beats_sent = 0;
  // rough element count, only used to steer the stimulus
  int unsigned             live_len = 0;
  bit                      idle_ok = 1'b0;

  int_vector_stack_engine dut (
    .clk, .rst, .start, .busy, .cmd, .index, .value, .ascending,
    .done, .read_value, .length, .status
  );

  ivs_stack_checker stack_watch (
    .clk, .rst, .start, .busy, .cmd, .index, .value, .ascending,
    .done, .read_value, .length, .status, .fail_count, .awaited
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) beat_taken <= start && !busy && !rst;

  // extremes now and then, a narrow band around zero so that ties show up in bubbling
  function automatic logic signed [VAL_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return '0;
          default: return -32'sd1;
        endcase
      end
      1, 2: return $signed($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  // random index over the whole field
  function automatic logic [IDX_W-1:0] rand_idx();
    return IDX_W'($urandom_range(0, 1023));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // drives one command beat at a falling edge and holds it until the block takes it;
  // start stays high afterwards so back-to-back beats never drop it
  task automatic issue(logic [CMD_W-1:0] c, logic [IDX_W-1:0] idx,
                       logic signed [VAL_W-1:0] val, logic asc);
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    start     <= 1'b1;
    cmd       <= c;
    index     <= idx;
    value     <= val;
    ascending <= asc;
    do @(negedge clk); while (!beat_taken);
    case (c)
      CMD_PUSH: if (live_len < DEPTH_DEF) live_len++;
      CMD_POP: if (live_len > 0) live_len--;
      CMD_SET: if (idx >= live_len) live_len = idx + 1;
      CMD_CLEAR: live_len = 0;
      default: ;
    endcase
    beats_sent++;
  endtask

  initial begin
    int unsigned n, k, idx, first_random;
    logic        up;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part: empty array first
    issue(CMD_POP, 10'h3ff, 32'sh7fff_ffff, 1'b1);
    issue(CMD_PEEK, 10'h000, -32'sd1, 1'b0);
    issue(CMD_BUBBLE, 10'h155, '0, 1'b1);
    issue(CMD_REVERSE, 10'h2aa, '0, 1'b0);
    // single element, bubble has nothing to move
    issue(CMD_PUSH, '0, 32'sh7fff_ffff, 1'b0);
    issue(CMD_BUBBLE, '0, '0, 1'b1);
    // most negative word bubbles to the front in ascending order
    issue(CMD_PUSH, '0, 32'sh8000_0000, 1'b0);
    issue(CMD_PEEK, '0, '0, 1'b0);
    issue(CMD_BUBBLE, '0, '0, 1'b1);
    issue(CMD_REVERSE, '0, '0, 1'b0);
    // set inside the length, then past it with a zero-filled gap
    issue(CMD_SET, 10'd1, -32'sd1, 1'b0);
    issue(CMD_SET, 10'd5, 32'sd123, 1'b0);
    issue(CMD_UNUSED, 10'h3ff, 32'sh5a5a_a5a5, 1'b1);
    issue(CMD_BUBBLE, '0, '0, 1'b0);
    issue(CMD_POP, '0, '0, 1'b0);
    issue(CMD_CLEAR, '0, '0, 1'b0);
    // last index fills the whole array, so the next push finds it full
    issue(CMD_SET, 10'd1023, 32'sh55aa_55aa, 1'b1);
    issue(CMD_PUSH, '0, 32'sh1234_5678, 1'b0);
    issue(CMD_REVERSE, '0, '0, 1'b0);
    issue(CMD_BUBBLE, '0, '0, 1'b1);
    issue(CMD_PEEK, '0, '0, 1'b0);
    issue(CMD_POP, '0, '0, 1'b0);
    issue(CMD_PUSH, '0, -32'sd7, 1'b0);
    issue(CMD_BUBBLE, '0, '0, 1'b0);
    issue(CMD_CLEAR, '0, '0, 1'b0);

    // random part, in short episodes
    first_random = beats_sent;
    while (beats_sent < first_random + RANDOM_BEATS) begin
      // gaps in bursts, with whole episodes left dense, and none near the end
      idle_ok = (beats_sent + CLOSING_RUN < first_random + RANDOM_BEATS)
                && $urandom_range(0, 2) != 0;
      // keep the array short most of the time so reverse and bubble stay quick
      if (live_len > 48 && $urandom_range(0, 3) != 0)
        issue(CMD_CLEAR, rand_idx(), $urandom, rand_bit());
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // insertion sort: every push followed by a bubble in one fixed order
          up = rand_bit();
          n  = $urandom_range(2, 10);
          repeat (n) begin
            issue(CMD_PUSH, rand_idx(), pick_word(), rand_bit());
            issue(CMD_BUBBLE, rand_idx(), $urandom, up);
          end
          k = $urandom_range(1, n);
          repeat (k)
            issue($urandom_range(0, 3) != 0 ? CMD_POP : CMD_PEEK, rand_idx(),
                  $urandom, rand_bit());
        end
        3, 4: begin
          repeat ($urandom_range(4, 12)) begin
            k = $urandom_range(0, 9);
            issue(k < 4 ? CMD_PUSH : k < 7 ? CMD_POP : k < 9 ? CMD_PEEK : CMD_BUBBLE,
                  rand_idx(), pick_word(), rand_bit());
          end
        end
        5: begin
          repeat (2) begin
            if ($urandom_range(0, 15) == 0) idx = $urandom_range(0, 1023);
            else if (live_len > 0 && $urandom_range(0, 1) != 0)
              idx = $urandom_range(0, live_len - 1);
            else begin
              idx = live_len + $urandom_range(0, 6);
              if (idx > 1023) idx = 1023;
            end
            issue(CMD_SET, IDX_W'(idx), pick_word(), rand_bit());
          end
        end
        6: begin
          issue(CMD_REVERSE, rand_idx(), $urandom, rand_bit());
          issue(CMD_PEEK, rand_idx(), $urandom, rand_bit());
          issue(CMD_BUBBLE, rand_idx(), $urandom, rand_bit());
        end
        7: begin
          if ($urandom_range(0, 1) != 0)
            issue(CMD_CLEAR, rand_idx(), $urandom, rand_bit());
          repeat ($urandom_range(0, 3))
            issue(CMD_PUSH, rand_idx(), pick_word(), rand_bit());
          issue(CMD_REVERSE, rand_idx(), $urandom, rand_bit());
        end
        8: begin
          // noise, the unused code included
          repeat (3)
            issue(CMD_W'($urandom_range(0, 7)), rand_idx(), $urandom, rand_bit());
        end
        default: begin
          // empty-array corner beats after a clear
          issue(CMD_CLEAR, rand_idx(), $urandom, rand_bit());
          issue(CMD_POP, rand_idx(), $urandom, rand_bit());
          issue(CMD_PEEK, rand_idx(), $urandom, rand_bit());
          issue(CMD_PUSH, rand_idx(), pick_word(), rand_bit());
          issue(CMD_BUBBLE, rand_idx(), $urandom, rand_bit());
          issue(CMD_REVERSE, rand_idx(), $urandom, rand_bit());
        end
      endcase
    end
    start <= 1'b0;

    // drain the outstanding replies, then a short quiet stretch to catch stray beats
    while (awaited != 0) @(negedge clk);
    repeat (64) @(negedge clk);
    if (fail_count == 0 && awaited == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(20_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== int_vector_stack_engine.f =====
sv/ivs_pkg.sv
sv/ivs_ctrl.sv
sv/ivs_dpath.sv
sv/int_vector_stack_engine.sv
test/ivs_stack_checker.sv
test/tb_top.sv
